// File: design/gps_time_to_calendar_macros.svh
// Assertion macros shared by the checker of the GPS time to calendar block.
// Depends on i_clk, i_rst_n and, for GTC_ASSERT_OUT, o_m_tvalid being visible where a macro is used.
`ifndef GPS_TIME_TO_CALENDAR_MACROS_SVH
`define GPS_TIME_TO_CALENDAR_MACROS_SVH

// A property that is checked at every clock edge outside reset.
`define GTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must hold whenever a result is offered on the output.
`define GTC_ASSERT_OUT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        o_m_tvalid |-> (cond)) else $error(msg);

`endif

// File: design/gtc_pkg.sv
// Package of the GPS time to calendar block: widths, scaled reciprocals and tables.
// Used by every module of the block; depends on nothing.
package gtc_pkg;

    localparam int WEEK_BITS_DEF = 13;
    localparam int MILLIS_W      = 30;
    localparam int NSTG          = 6;

    // Internal widths, sized for the largest supported week number.
    localparam int B_W     = 22;
    localparam int X_W     = 29;
    localparam int MSD_W   = 27;
    localparam int C_W     = 13;
    localparam int D_W     = 24;
    localparam int Y_W     = 9;
    localparam int E_W     = 4;
    localparam int REMH_W  = 22;
    localparam int REMM_W  = 16;

    localparam logic [MILLIS_W-1:0] MS_WEEK_MAX = 30'd604799999;
    // Julian day number at the epoch plus the 1537 day offset.
    localparam logic [B_W-1:0] B_BASE = 22'd2445782;
    // 100 * B_BASE - 12210, the scaled form of b - 122.1.
    localparam logic [X_W-1:0] X_BASE = 29'd244565990;
    localparam logic [C_W-1:0] YEAR_OFS = 13'd4715;

    // Exact reciprocals: floor(x / d) = (x * M) >> K for x below 2**N,
    // with K = N + ceil(log2 d) and M = ceil(2**K / d).
    localparam int KC   = 45;
    localparam int MC_W = 30;
    localparam int PC_W = X_W + MC_W;
    localparam logic [MC_W-1:0] MC = MC_W'(((64'd1 << KC) + 64'd36524) / 64'd36525);

    localparam int KH   = 49;
    localparam int MH_W = 28;
    localparam int PH_W = MSD_W + MH_W;
    localparam logic [MH_W-1:0] MH = MH_W'(((64'd1 << KH) + 64'd3599999) / 64'd3600000);

    localparam int KM   = 38;
    localparam int MM_W = 23;
    localparam int PM_W = REMH_W + MM_W;
    localparam logic [MM_W-1:0] MM = MM_W'(((64'd1 << KM) + 64'd59999) / 64'd60000);

    localparam int KS   = 26;
    localparam int MS_W = 17;
    localparam int PS_W = REMM_W + MS_W;
    localparam logic [MS_W-1:0] MS = MS_W'(((64'd1 << KS) + 64'd999) / 64'd1000);

    typedef logic [6:0][MILLIS_W-1:0] t_day_tab;
    typedef logic [23:0][MSD_W-1:0]   t_hour_tab;
    typedef logic [59:0][REMH_W-1:0]  t_min_tab;
    typedef logic [59:0][REMM_W-1:0]  t_sec_tab;
    typedef logic [15:0][Y_W-1:0]     t_mon_tab;

    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_pipe_ctl;

    typedef struct packed {
        logic [9:0]  millis;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_cal_out;

    function automatic t_day_tab build_day_tab();
        t_day_tab t;
        for (int k = 0; k < 7; k++) begin
            t[k] = MILLIS_W'(k * 86400000);
        end
        return t;
    endfunction

    function automatic t_hour_tab build_hour_tab();
        t_hour_tab t;
        for (int k = 0; k < 24; k++) begin
            t[k] = MSD_W'(k * 3600000);
        end
        return t;
    endfunction

    function automatic t_min_tab build_min_tab();
        t_min_tab t;
        for (int k = 0; k < 60; k++) begin
            t[k] = REMH_W'(k * 60000);
        end
        return t;
    endfunction

    function automatic t_sec_tab build_sec_tab();
        t_sec_tab t;
        for (int k = 0; k < 60; k++) begin
            t[k] = REMM_W'(k * 1000);
        end
        return t;
    endfunction

    // Smallest day count y with floor(y / 30.6001) >= k.
    function automatic t_mon_tab build_thr_tab();
        t_mon_tab t;
        for (int k = 0; k < 16; k++) begin
            t[k] = Y_W'((k * 306001 + 9999) / 10000);
        end
        return t;
    endfunction

    // floor(k * 30.6001).
    function automatic t_mon_tab build_ft_tab();
        t_mon_tab t;
        for (int k = 0; k < 16; k++) begin
            t[k] = Y_W'((k * 306001) / 10000);
        end
        return t;
    endfunction

    localparam t_day_tab  DAY_MS  = build_day_tab();
    localparam t_hour_tab HOUR_MS = build_hour_tab();
    localparam t_min_tab  MIN_MS  = build_min_tab();
    localparam t_sec_tab  SEC_MS  = build_sec_tab();
    localparam t_mon_tab  THR     = build_thr_tab();
    localparam t_mon_tab  FT      = build_ft_tab();

endpackage

// File: design/gtc_ctrl.sv
// Valid bits and stage enables of the six stage pipeline.
// Depends on gtc_pkg.
module gtc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output gtc_pkg::t_pipe_ctl  o_ctl
);

    logic [gtc_pkg::NSTG-1:0] r_vld;
    logic [gtc_pkg::NSTG-1:0] n_vld;
    logic [gtc_pkg::NSTG-1:0] w_en;

    // A stage loads when it is empty or when its contents move on, so bubbles close up.
    always_comb begin
        w_en[gtc_pkg::NSTG-1] = !r_vld[gtc_pkg::NSTG-1] || i_m_tready;
        for (int k = gtc_pkg::NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_s_tvalid : r_vld[0];
        for (int k = 1; k < gtc_pkg::NSTG; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en   = w_en;
    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_vld[gtc_pkg::NSTG-1];

endmodule

// File: design/gtc_front.sv
// First stage: saturation of the millisecond count, day of week, day number and its scaled form.
// Depends on gtc_pkg.
module gtc_front #(
    parameter int WEEK_BITS = gtc_pkg::WEEK_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [WEEK_BITS-1:0]          i_week,
    input  logic [gtc_pkg::MILLIS_W-1:0]  i_ms,
    output logic [gtc_pkg::B_W-1:0]       o_b,
    output logic [gtc_pkg::X_W-1:0]       o_x,
    output logic [gtc_pkg::MSD_W-1:0]     o_msd
);

    logic [gtc_pkg::MILLIS_W-1:0] w_ms_sat;
    logic [2:0]                   w_dow;
    logic [gtc_pkg::B_W-1:0]      n_b;
    logic [gtc_pkg::X_W-1:0]      n_x;
    logic [gtc_pkg::MSD_W-1:0]    n_msd;
    logic [gtc_pkg::B_W-1:0]      r_b;
    logic [gtc_pkg::X_W-1:0]      r_x;
    logic [gtc_pkg::MSD_W-1:0]    r_msd;

    // The day compares look at the raw count: a saturated count passes all of them anyway.
    always_comb begin
        w_ms_sat = (i_ms > gtc_pkg::MS_WEEK_MAX) ? gtc_pkg::MS_WEEK_MAX : i_ms;
        w_dow    = '0;
        for (int k = 1; k < 7; k++) begin
            if (i_ms >= gtc_pkg::DAY_MS[k]) begin
                w_dow = 3'(k);
            end
        end
        n_msd = gtc_pkg::MSD_W'(w_ms_sat - gtc_pkg::DAY_MS[w_dow]);
        n_b   = gtc_pkg::B_BASE + (gtc_pkg::B_W'(i_week) << 3) - gtc_pkg::B_W'(i_week)
              + gtc_pkg::B_W'(w_dow);
        n_x   = gtc_pkg::X_BASE + gtc_pkg::X_W'(i_week) * gtc_pkg::X_W'(700)
              + gtc_pkg::X_W'(w_dow) * gtc_pkg::X_W'(100);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b   <= n_b;
            r_x   <= n_x;
            r_msd <= n_msd;
        end
    end

    assign o_b   = r_b;
    assign o_x   = r_x;
    assign o_msd = r_msd;

endmodule

// File: design/gtc_date.sv
// Date path, stages two to six: day number to year, month and day of month.
// Depends on gtc_pkg.
module gtc_date (
    input  logic                     i_clk,
    input  gtc_pkg::t_pipe_ctl       i_ctl,
    input  logic [gtc_pkg::B_W-1:0]  i_b,
    input  logic [gtc_pkg::X_W-1:0]  i_x,
    output logic [11:0]              o_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day
);

    logic [gtc_pkg::PC_W-1:0] n_pc;
    logic [gtc_pkg::PC_W-1:0] r_pc;
    logic [gtc_pkg::B_W-1:0]  r_b2;

    logic [gtc_pkg::C_W-1:0]  n_c;
    logic [gtc_pkg::D_W-1:0]  w_d;
    logic [gtc_pkg::Y_W-1:0]  n_y;
    logic [gtc_pkg::C_W-1:0]  r_c3;
    logic [gtc_pkg::Y_W-1:0]  r_y3;

    logic [gtc_pkg::E_W-1:0]  w_e;
    logic [gtc_pkg::Y_W-1:0]  w_dd;
    logic [3:0]               n_month;
    logic [11:0]              n_year;
    logic [11:0]              r_year4, r_year5, r_year6;
    logic [3:0]               r_month4, r_month5, r_month6;
    logic [4:0]               r_day4, r_day5, r_day6;

    // Stage two: c = (100 b - 12210) / 36525 through its reciprocal.
    assign n_pc = gtc_pkg::PC_W'(i_x) * gtc_pkg::PC_W'(gtc_pkg::MC);

    // Stage three: d = floor(365.25 c) and the day count within the shifted year.
    always_comb begin
        n_c = gtc_pkg::C_W'(r_pc >> gtc_pkg::KC);
        w_d = (gtc_pkg::D_W'(n_c) * gtc_pkg::D_W'(1461)) >> 2;
        n_y = gtc_pkg::Y_W'(r_b2 - gtc_pkg::B_W'(w_d));
    end

    // Stage four: e = floor(y / 30.6001) from thresholds, then day, month and year.
    always_comb begin
        w_e = '0;
        for (int k = 1; k < 16; k++) begin
            if (r_y3 >= gtc_pkg::THR[k]) begin
                w_e = gtc_pkg::E_W'(k);
            end
        end
        w_dd = r_y3 - gtc_pkg::FT[w_e];
        if (w_e >= 4'd14) begin
            n_month = w_e - 4'd13;
        end else begin
            n_month = w_e - 4'd1;
        end
        // January and February belong to the year after the shifted one.
        n_year = 12'(r_c3 - gtc_pkg::YEAR_OFS - gtc_pkg::C_W'(n_month >= 4'd3));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_pc <= n_pc;
            r_b2 <= i_b;
        end
        if (i_ctl.en[2]) begin
            r_c3 <= n_c;
            r_y3 <= n_y;
        end
        if (i_ctl.en[3]) begin
            r_year4  <= n_year;
            r_month4 <= n_month;
            r_day4   <= 5'(w_dd);
        end
        if (i_ctl.en[4]) begin
            r_year5  <= r_year4;
            r_month5 <= r_month4;
            r_day5   <= r_day4;
        end
        if (i_ctl.en[5]) begin
            r_year6  <= r_year5;
            r_month6 <= r_month5;
            r_day6   <= r_day5;
        end
    end

    assign o_year  = r_year6;
    assign o_month = r_month6;
    assign o_day   = r_day6;

endmodule

// File: design/gtc_tod.sv
// Time of day path, stages two to six: millisecond of the day to hour, minute, second, millisecond.
// Depends on gtc_pkg.
module gtc_tod (
    input  logic                       i_clk,
    input  gtc_pkg::t_pipe_ctl         i_ctl,
    input  logic [gtc_pkg::MSD_W-1:0]  i_msd,
    output logic [4:0]                 o_hour,
    output logic [5:0]                 o_minute,
    output logic [5:0]                 o_second,
    output logic [9:0]                 o_millis
);

    logic [gtc_pkg::PH_W-1:0]   n_ph;
    logic [gtc_pkg::PH_W-1:0]   r_ph2;
    logic [gtc_pkg::MSD_W-1:0]  r_msd2;

    logic [4:0]                 n_hour;
    logic [gtc_pkg::REMH_W-1:0] n_remh;
    logic [4:0]                 r_hour3, r_hour4, r_hour5, r_hour6;
    logic [gtc_pkg::REMH_W-1:0] r_remh3, r_remh4;

    logic [gtc_pkg::PM_W-1:0]   n_pm;
    logic [gtc_pkg::PM_W-1:0]   r_pm4;

    logic [5:0]                 n_minute;
    logic [gtc_pkg::REMM_W-1:0] n_remm;
    logic [gtc_pkg::PS_W-1:0]   n_ps;
    logic [5:0]                 r_minute5, r_minute6;
    logic [gtc_pkg::REMM_W-1:0] r_remm5;
    logic [gtc_pkg::PS_W-1:0]   r_ps5;

    logic [5:0]                 n_second;
    logic [9:0]                 n_millis;
    logic [5:0]                 r_second6;
    logic [9:0]                 r_millis6;

    assign n_ph = gtc_pkg::PH_W'(i_msd) * gtc_pkg::PH_W'(gtc_pkg::MH);

    always_comb begin
        n_hour = 5'(r_ph2 >> gtc_pkg::KH);
        n_remh = gtc_pkg::REMH_W'(r_msd2 - gtc_pkg::HOUR_MS[n_hour]);
    end

    assign n_pm = gtc_pkg::PM_W'(r_remh3) * gtc_pkg::PM_W'(gtc_pkg::MM);

    always_comb begin
        n_minute = 6'(r_pm4 >> gtc_pkg::KM);
        n_remm   = gtc_pkg::REMM_W'(r_remh4 - gtc_pkg::MIN_MS[n_minute]);
        n_ps     = gtc_pkg::PS_W'(n_remm) * gtc_pkg::PS_W'(gtc_pkg::MS);
    end

    always_comb begin
        n_second = 6'(r_ps5 >> gtc_pkg::KS);
        n_millis = 10'(r_remm5 - gtc_pkg::SEC_MS[n_second]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_ph2  <= n_ph;
            r_msd2 <= i_msd;
        end
        if (i_ctl.en[2]) begin
            r_hour3 <= n_hour;
            r_remh3 <= n_remh;
        end
        if (i_ctl.en[3]) begin
            r_hour4 <= r_hour3;
            r_remh4 <= r_remh3;
            r_pm4   <= n_pm;
        end
        if (i_ctl.en[4]) begin
            r_hour5   <= r_hour4;
            r_minute5 <= n_minute;
            r_remm5   <= n_remm;
            r_ps5     <= n_ps;
        end
        if (i_ctl.en[5]) begin
            r_hour6   <= r_hour5;
            r_minute6 <= r_minute5;
            r_second6 <= n_second;
            r_millis6 <= n_millis;
        end
    end

    assign o_hour   = r_hour6;
    assign o_minute = r_minute6;
    assign o_second = r_second6;
    assign o_millis = r_millis6;

endmodule

// File: design/gps_time_to_calendar.sv
// Converts a GPS week number and millisecond of the week into a Gregorian date and time of day.
// Top level; depends on gtc_pkg, gtc_ctrl, gtc_front, gtc_date and gtc_tod.
//
// One transfer in gives one transfer out, in order. The block takes a new item every clock
// cycle while its output is not stalled, and passes each item through its six register
// stages, which hold the scaled reciprocal multiplies standing in for the divisions by 36525,
// 3600000, 60000 and 1000. A stalled output only halts the stages that are full, so empty
// stages keep taking input. Week bits above WEEK_BITS are ignored, and a millisecond count past
// the end of the week is read as the last millisecond of the week. Dates from 2100-03-01 on are
// one day behind the true Gregorian date, as every fourth year is taken as a leap year. No
// state is kept between items and there is no start-up pass after reset.
module gps_time_to_calendar #(
    parameter int WEEK_BITS = gtc_pkg::WEEK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // gps_week [WEEK_BITS-1:0], week_millis [WEEK_BITS+29:WEEK_BITS], zero padding above
    input  logic [((WEEK_BITS + gtc_pkg::MILLIS_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // year [11:0], month [15:12], day [20:16], hour [25:21], minute [31:26],
    // second [37:32], millis [47:38]
    output logic [47:0]           o_m_tdata
);

    gtc_pkg::t_pipe_ctl              w_ctl;
    logic [gtc_pkg::B_W-1:0]         w_b;
    logic [gtc_pkg::X_W-1:0]         w_x;
    logic [gtc_pkg::MSD_W-1:0]       w_msd;
    gtc_pkg::t_cal_out               w_cal;

    gtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctl      (w_ctl)
    );

    gtc_front #(
        .WEEK_BITS (WEEK_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_en   (w_ctl.en[0]),
        .i_week (i_s_tdata[WEEK_BITS-1:0]),
        .i_ms   (i_s_tdata[WEEK_BITS +: gtc_pkg::MILLIS_W]),
        .o_b    (w_b),
        .o_x    (w_x),
        .o_msd  (w_msd)
    );

    gtc_date u_date (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_b     (w_b),
        .i_x     (w_x),
        .o_year  (w_cal.year),
        .o_month (w_cal.month),
        .o_day   (w_cal.day)
    );

    gtc_tod u_tod (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_msd    (w_msd),
        .o_hour   (w_cal.hour),
        .o_minute (w_cal.minute),
        .o_second (w_cal.second),
        .o_millis (w_cal.millis)
    );

    assign o_m_tdata = w_cal;

endmodule

// File: design/gtc_checker.sv
// Port-level checks of the GPS time to calendar block, bound to its top level.
// Depends on gtc_pkg and gps_time_to_calendar_macros.svh.
`include "gps_time_to_calendar_macros.svh"

module gtc_checker #(
    parameter int WEEK_BITS = gtc_pkg::WEEK_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [((WEEK_BITS + gtc_pkg::MILLIS_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    logic [3:0]        r_cnt;
    logic [3:0]        n_cnt;
    gtc_pkg::t_cal_out w_cal;

    // Items taken in but not yet handed out.
    always_comb begin
        n_cnt = r_cnt + 4'(i_s_tvalid && o_s_tready) - 4'(o_m_tvalid && i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign w_cal = o_m_tdata;

    `GTC_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    `GTC_ASSERT(a_ready_free, (!o_m_tvalid || i_m_tready) |-> o_s_tready, "input stalled with free pipeline")
    `GTC_ASSERT_OUT(a_occupancy, r_cnt != 4'd0 && r_cnt <= 4'(gtc_pkg::NSTG), "result without a matching input")
    `GTC_ASSERT_OUT(a_ranges, w_cal.month != 4'd0 && w_cal.month <= 4'd12 && w_cal.day != 5'd0 && w_cal.hour <= 5'd23 && w_cal.minute <= 6'd59 && w_cal.second <= 6'd59 && w_cal.millis <= 10'd999, "calendar field out of range")

    // The input data is watched only through the transfer count.
    logic w_unused_data;
    assign w_unused_data = ^i_s_tdata;

endmodule

bind gps_time_to_calendar gtc_checker #(.WEEK_BITS(WEEK_BITS)) u_gtc_checker (.*);
